// ----- rtl/glr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the glyph line rasterizer.
// No dependencies.
package glr_pkg;

    localparam int GRID_SIZE   = 64;
    localparam int COORD_W     = 6;
    localparam int CANVAS_W    = 7;
    localparam int GLYPH_W     = 8;
    localparam int COLOR_W     = 4;
    localparam int ERR_W       = 9;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;

    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 7'd64;
    localparam logic [CANVAS_W-1:0] GRID_LIMIT   = CANVAS_W'(GRID_SIZE);

    localparam logic [GLYPH_W-1:0] GLYPH_VERT = 8'h7C;
    localparam logic [GLYPH_W-1:0] GLYPH_HORZ = 8'h2D;
    localparam logic [GLYPH_W-1:0] GLYPH_RISE = 8'h2F;
    localparam logic [GLYPH_W-1:0] GLYPH_FALL = 8'h5C;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [GLYPH_W-1:0] override_glyph;
        logic [COLOR_W-1:0] color_tag;
    } t_cmd;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [GLYPH_W-1:0] glyph;
        logic [COLOR_W-1:0] pixel_color;
        logic               visible;
        logic               last_pixel;
    } t_pixel;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture a new command
        logic emit;   // write current pixel to the output register and step
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a beat this cycle
        logic at_end;    // current walk position equals the end point
    } t_dp_stat;

endpackage

// ----- rtl/glr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the glyph line rasterizer: idle/walk state machine.
// Depends on glr_pkg.
module glr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  glr_pkg::t_dp_stat i_stat,
    output glr_pkg::t_dp_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    // leave once the end point has gone out
                    if (i_stat.at_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/glr_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the glyph line rasterizer: walk registers, error term,
// canvas registers and output register. Depends on glr_pkg.
module glr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [glr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [glr_pkg::CANVAS_W-1:0]        i_cfg_data,
    input  glr_pkg::t_cmd                       i_cmd_data,
    input  glr_pkg::t_dp_cmd                    i_cmd,
    output glr_pkg::t_dp_stat                   o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output glr_pkg::t_pixel                     o_out_data
);

    logic [glr_pkg::CANVAS_W-1:0] r_canvas_w;
    logic [glr_pkg::CANVAS_W-1:0] r_canvas_h;

    logic [glr_pkg::COORD_W-1:0]  r_x, r_y, r_xe, r_ye;
    logic [glr_pkg::COORD_W-1:0]  r_adx, r_ady;
    logic                         r_sx_neg, r_sy_neg;
    logic signed [glr_pkg::ERR_W-1:0] r_err;
    logic [glr_pkg::GLYPH_W-1:0]  r_glyph;
    logic [glr_pkg::COLOR_W-1:0]  r_color;

    logic            r_out_valid;
    glr_pkg::t_pixel r_out;

    // load-time values
    logic [glr_pkg::COORD_W-1:0]  n_adx, n_ady;
    logic [glr_pkg::COORD_W:0]    adx2, ady2;
    logic                         n_sx_neg, n_sy_neg;
    logic [glr_pkg::GLYPH_W-1:0]  slope_glyph;

    // step values
    logic signed [glr_pkg::ERR_W:0]   e2;
    logic signed [glr_pkg::ERR_W:0]   adx_s, ady_s;
    logic                             step_x, step_y;
    logic signed [glr_pkg::ERR_W-1:0] n_err;
    logic [glr_pkg::CANVAS_W-1:0]     wlim, hlim;
    logic                             vis;

    always_comb begin
        n_sx_neg = !(i_cmd_data.start_x < i_cmd_data.end_x);
        n_sy_neg = !(i_cmd_data.start_y < i_cmd_data.end_y);
        n_adx = (i_cmd_data.end_x > i_cmd_data.start_x)
              ? i_cmd_data.end_x - i_cmd_data.start_x
              : i_cmd_data.start_x - i_cmd_data.end_x;
        n_ady = (i_cmd_data.end_y > i_cmd_data.start_y)
              ? i_cmd_data.end_y - i_cmd_data.start_y
              : i_cmd_data.start_y - i_cmd_data.end_y;
        adx2 = {n_adx, 1'b0};
        ady2 = {n_ady, 1'b0};
        if (n_adx == '0) begin
            slope_glyph = glr_pkg::GLYPH_VERT;
        end else if (n_ady == '0) begin
            slope_glyph = glr_pkg::GLYPH_HORZ;
        end else if (ady2 < {1'b0, n_adx}) begin
            slope_glyph = glr_pkg::GLYPH_HORZ;
        end else if ({1'b0, n_ady} < adx2) begin
            slope_glyph = (n_sx_neg == n_sy_neg) ? glr_pkg::GLYPH_FALL
                                                 : glr_pkg::GLYPH_RISE;
        end else begin
            slope_glyph = glr_pkg::GLYPH_VERT;
        end
    end

    always_comb begin
        adx_s  = $signed({{(glr_pkg::ERR_W+1-glr_pkg::COORD_W){1'b0}}, r_adx});
        ady_s  = $signed({{(glr_pkg::ERR_W+1-glr_pkg::COORD_W){1'b0}}, r_ady});
        e2     = $signed({r_err, 1'b0});
        step_x = (e2 >= -ady_s);
        step_y = (e2 <= adx_s);
        n_err  = r_err;
        if (step_x) begin
            n_err = n_err - ady_s[glr_pkg::ERR_W-1:0];
        end
        if (step_y) begin
            n_err = n_err + adx_s[glr_pkg::ERR_W-1:0];
        end
        wlim = (r_canvas_w < glr_pkg::GRID_LIMIT) ? r_canvas_w : glr_pkg::GRID_LIMIT;
        hlim = (r_canvas_h < glr_pkg::GRID_LIMIT) ? r_canvas_h : glr_pkg::GRID_LIMIT;
        vis  = ({1'b0, r_x} < wlim) && ({1'b0, r_y} < hlim);
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.at_end   = (r_x == r_xe) && (r_y == r_ye);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= glr_pkg::CANVAS_RESET;
            r_canvas_h <= glr_pkg::CANVAS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                glr_pkg::REG_CANVAS_WIDTH:  r_canvas_w <= i_cfg_data;
                glr_pkg::REG_CANVAS_HEIGHT: r_canvas_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x      <= i_cmd_data.start_x;
            r_y      <= i_cmd_data.start_y;
            r_xe     <= i_cmd_data.end_x;
            r_ye     <= i_cmd_data.end_y;
            r_adx    <= n_adx;
            r_ady    <= n_ady;
            r_sx_neg <= n_sx_neg;
            r_sy_neg <= n_sy_neg;
            r_err    <= glr_pkg::ERR_W'($signed({1'b0, n_adx})) -
                        glr_pkg::ERR_W'($signed({1'b0, n_ady}));
            r_glyph  <= (i_cmd_data.override_glyph != '0) ? i_cmd_data.override_glyph
                                                          : slope_glyph;
            r_color  <= i_cmd_data.color_tag;
        end else if (i_cmd.emit) begin
            r_err <= n_err;
            if (step_x) begin
                r_x <= r_sx_neg ? r_x - 1'b1 : r_x + 1'b1;
            end
            if (step_y) begin
                r_y <= r_sy_neg ? r_y - 1'b1 : r_y + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.pixel_x     <= r_x;
            r_out.pixel_y     <= r_y;
            r_out.glyph       <= r_glyph;
            r_out.pixel_color <= r_color;
            r_out.visible     <= vis;
            r_out.last_pixel  <= o_stat.at_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/glyph_line_rasterizer_top.sv -----
`timescale 1ns / 1ps
// Glyph line rasterizer: walks an all-octant Bresenham line, one pixel beat per cycle
// while the output register is free; each pixel is registered in the output register.
// Each command yields max(|dx|,|dy|)+1 beats (1 to 64) from the single error-term
// update loop in the datapath; a new command waits until the end point has gone out.
// Reset (synchronous, active low): controller idle, output empty, canvas 64x64.
// Depends on glr_pkg, glr_ctrl, glr_datapath.
module glyph_line_rasterizer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  glr_pkg::t_cmd                    i_in_data,
    // pixel channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output glr_pkg::t_pixel                  o_out_data,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [glr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [glr_pkg::CANVAS_W-1:0]     i_cfg_data
);

    glr_pkg::t_dp_cmd  dp_cmd;
    glr_pkg::t_dp_stat dp_stat;

    // Controller: accept a command when idle, then advance one pixel each
    // time the output register can take a beat; drop back to idle after
    // the end point goes out.
    glr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Datapath: holds the walk position, error term and glyph; the output
    // register keeps the last pixel beat while a new command loads.
    glr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_data  (i_in_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- bench/glyph_line_rasterizer_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for glyph_line_rasterizer_top: line commands in, pixel beats out.
// Depends on glr_pkg and the rasterizer RTL; predicts every pixel with its own line walk.
module glyph_line_rasterizer_top_test;

    // Give up after this many cycles with no beat on either channel. The
    // longest quiet stretch of a good run is the forced receiver hold-off.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cycles to keep watching the pixel channel once everything has drained.
    localparam int TAIL_CYCLES    = 10;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int MAX_GAP        = 30;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    glr_pkg::t_cmd                     i_in_data = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    glr_pkg::t_pixel                   o_out_data;
    logic                              i_cfg_we = 1'b0;
    logic [glr_pkg::CFG_INDEX_W-1:0]   i_cfg_index = glr_pkg::REG_CANVAS_WIDTH;
    logic [glr_pkg::CANVAS_W-1:0]      i_cfg_data = '0;

    // Canvas size as the bench believes the block holds it.
    int     canvas_cols = 64;
    int     canvas_rows = 64;

    // Pixels still owed by the block, oldest first.
    glr_pkg::t_pixel expected_pixels[$];
    glr_pkg::t_pixel want_pixel;
    int     mismatch_count = 0;

    // Idle percentages of both sides and the pending forced stall length.
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     rx_hold_left = 0;
    int     quiet_cycles = 0;

    glyph_line_rasterizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line walk predictor: push every pixel that one command should yield.
    // ------------------------------------------------------------------
    function automatic void predict_line(glr_pkg::t_cmd c);
        int x, y, xe, ye;
        int dx, ady, dy, sx, sy, err, e2;
        int col_lim, row_lim;
        logic [glr_pkg::GLYPH_W-1:0] g;
        glr_pkg::t_pixel p;
        bit done;
        x = c.start_x;
        y = c.start_y;
        xe = c.end_x;
        ye = c.end_y;
        dx = (xe > x) ? xe - x : x - xe;
        ady = (ye > y) ? ye - y : y - ye;
        dy = -ady;
        sx = (x < xe) ? 1 : -1;
        sy = (y < ye) ? 1 : -1;
        err = dx + dy;

        // Slope glyph from exact integer compares; a nonzero override wins.
        if (c.override_glyph != '0) g = c.override_glyph;
        else if (dx == 0) g = glr_pkg::GLYPH_VERT;
        else if (ady == 0) g = glr_pkg::GLYPH_HORZ;
        else if (2 * ady < dx) g = glr_pkg::GLYPH_HORZ;
        else if (ady < 2 * dx) g = (sx == sy) ? glr_pkg::GLYPH_FALL : glr_pkg::GLYPH_RISE;
        else g = glr_pkg::GLYPH_VERT;

        // A canvas wider than the grid is still clipped by the grid.
        col_lim = (canvas_cols < glr_pkg::GRID_SIZE) ? canvas_cols : glr_pkg::GRID_SIZE;
        row_lim = (canvas_rows < glr_pkg::GRID_SIZE) ? canvas_rows : glr_pkg::GRID_SIZE;

        for (int n = 0; n < 64; n++) begin
            done = (x == xe) && (y == ye);
            p.pixel_x     = x[glr_pkg::COORD_W-1:0];
            p.pixel_y     = y[glr_pkg::COORD_W-1:0];
            p.glyph       = g;
            p.pixel_color = c.color_tag;
            p.visible     = (x < col_lim) && (y < row_lim);
            p.last_pixel  = done;
            expected_pixels.push_back(p);
            if (done) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                x += sx;
            end
            if (e2 <= dx) begin
                err += dx;
                y += sy;
            end
        end
    endfunction

    function automatic glr_pkg::t_cmd make_cmd(int x0, int y0, int x1, int y1, int ovr,
                                               int col);
        glr_pkg::t_cmd c;
        c.start_x        = glr_pkg::COORD_W'(x0);
        c.start_y        = glr_pkg::COORD_W'(y0);
        c.end_x          = glr_pkg::COORD_W'(x1);
        c.end_y          = glr_pkg::COORD_W'(y1);
        c.override_glyph = glr_pkg::GLYPH_W'(ovr);
        c.color_tag      = glr_pkg::COLOR_W'(col);
        return c;
    endfunction

    // Random command: free endpoints half the time, else one of the
    // shapes that decide the glyph (points, axes, diagonals, 2:1 ratios).
    function automatic glr_pkg::t_cmd random_cmd();
        int x0, y0, x1, y1, d, shape, ovr, tmp;
        x0 = $urandom_range(63);
        y0 = $urandom_range(63);
        x1 = $urandom_range(63);
        y1 = $urandom_range(63);
        shape = $urandom_range(9);
        case (shape)
            0: begin
                x1 = x0;
                y1 = y0;
            end
            1: y1 = y0;
            2: x1 = x0;
            3: begin
                d = $urandom_range(1, 31);
                x1 = (x0 + d <= 63) ? x0 + d : x0 - d;
                y1 = (y0 + d <= 63) ? y0 + d : y0 - d;
            end
            4: begin
                // Exactly on the boundary between straight and diagonal.
                d = $urandom_range(1, 15);
                x1 = (x0 + 2 * d <= 63) ? x0 + 2 * d : x0 - 2 * d;
                y1 = (y0 + d <= 63) ? y0 + d : y0 - d;
                if ($urandom_range(1)) begin
                    tmp = x0; x0 = y0; y0 = tmp;
                    tmp = x1; x1 = y1; y1 = tmp;
                end
            end
            default: ;
        endcase
        ovr = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 255);
        return make_cmd(x0, y0, x1, y1, ovr, $urandom_range(15));
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one command beat, maybe after an idle gap, and hold it until
    // accepted. Valid stays high afterwards so back-to-back beats need no
    // drop; wait_drained lowers it.
    task automatic send_cmd(glr_pkg::t_cmd c);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        predict_line(c);
    endtask

    // Drop the command valid and wait until every owed pixel has arrived.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Write the width register, then the height register; block is idle.
    task automatic set_canvas(int cols, int rows);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= glr_pkg::REG_CANVAS_WIDTH;
        i_cfg_data  <= glr_pkg::CANVAS_W'(cols);
        @(posedge i_clk);
        i_cfg_index <= glr_pkg::REG_CANVAS_HEIGHT;
        i_cfg_data  <= glr_pkg::CANVAS_W'(rows);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        canvas_cols = cols;
        canvas_rows = rows;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Glyph selection and walk order at reset canvas: single points,
    // full-grid axes and diagonals in every direction, exact slope
    // boundaries, overrides and the colour extremes.
    task automatic test_slope_glyphs();
        glr_pkg::t_cmd cmds[$];
        cmds.push_back(make_cmd( 0,  0,  0,  0,   0,  0));
        cmds.push_back(make_cmd(63, 63, 63, 63,   0, 15));
        cmds.push_back(make_cmd( 0,  0, 63,  0,   0,  1));
        cmds.push_back(make_cmd(63,  5,  0,  5,   0,  2));
        cmds.push_back(make_cmd( 7,  0,  7, 63,   0,  3));
        cmds.push_back(make_cmd(40, 63, 40,  0,   0,  4));
        cmds.push_back(make_cmd( 0,  0, 63, 63,   0,  5));
        cmds.push_back(make_cmd(63, 63,  0,  0,   0,  6));
        cmds.push_back(make_cmd( 0, 63, 63,  0,   0,  7));
        cmds.push_back(make_cmd(63,  0,  0, 63,   0,  8));
        cmds.push_back(make_cmd( 0,  0, 10,  5,   0,  9));
        cmds.push_back(make_cmd( 0,  0, 11,  5,   0, 10));
        cmds.push_back(make_cmd( 0,  0,  5, 10,   0, 11));
        cmds.push_back(make_cmd( 0,  0,  5,  9,   0, 12));
        cmds.push_back(make_cmd(20, 20, 10, 25,   0, 13));
        cmds.push_back(make_cmd(30, 30, 33, 10,   0, 14));
        cmds.push_back(make_cmd( 5,  5, 60,  6,   0, 15));
        cmds.push_back(make_cmd( 0,  0, 63, 63, 255, 15));
        cmds.push_back(make_cmd(63,  0,  0, 31,   1,  5));
        cmds.push_back(make_cmd(12, 34, 12, 34, 128, 10));
        cmds.push_back(make_cmd( 1, 62, 62,  1,  42,  9));
        cmds.push_back(make_cmd(63, 63,  0, 62,   0,  0));
        foreach (cmds[i]) send_cmd(cmds[i]);
        wait_drained();
    endtask

    // Visibility against canvas extremes: empty canvas, one cell, sizes
    // past the grid, thin strips and one short of the grid.
    task automatic test_canvas_limits();
        int sizes[7][2] = '{'{0, 0}, '{1, 1}, '{127, 127}, '{64, 1},
                            '{1, 64}, '{63, 63}, '{65, 64}};
        foreach (sizes[i]) begin
            set_canvas(sizes[i][0], sizes[i][1]);
            repeat (4) send_cmd(random_cmd());
            wait_drained();
        end
    endtask

    // Random lines under three idling mixes, a fresh canvas for each.
    task automatic test_random_lines();
        int mixes[3][2] = '{'{11, 70}, '{70, 11}, '{0, 0}};
        foreach (mixes[i]) begin
            tx_idle_pct = mixes[i][0];
            rx_idle_pct = mixes[i][1];
            set_canvas($urandom_range(1, 64), $urandom_range(1, 64));
            repeat (40) send_cmd(random_cmd());
            wait_drained();
        end
    endtask

    // Stall the pixel channel for a long stretch while commands keep
    // coming, so the block fills and must push back on its input.
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_canvas(64, 64);
        rx_hold_left = HOLD_OFF_LEN;
        repeat (12) send_cmd(random_cmd());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Drive ready: a forced hold-off when one is pending, else random idling.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each pixel beat with the oldest owed pixel.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel beat, expected none, actual %h",
                         $time, o_out_data);
                mismatch_count++;
            end else begin
                want_pixel = expected_pixels.pop_front();
                check_field("pixel_x", want_pixel.pixel_x, o_out_data.pixel_x);
                check_field("pixel_y", want_pixel.pixel_y, o_out_data.pixel_y);
                check_field("glyph", want_pixel.glyph, o_out_data.glyph);
                check_field("pixel_color", want_pixel.pixel_color, o_out_data.pixel_color);
                check_field("visible", want_pixel.visible, o_out_data.visible);
                check_field("last_pixel", want_pixel.last_pixel, o_out_data.last_pixel);
            end
        end
    end

    // Count cycles with no beat on either channel; stop a hung run.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 11;
        rx_idle_pct = 70;
        test_slope_glyphs();
        test_canvas_limits();
        test_random_lines();
        test_output_backpressure();

        // Hold on a little longer to catch any stray beat.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d pixels never arrived", $time, expected_pixels.size());
            mismatch_count++;
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/glr_pkg.sv
rtl/glr_ctrl.sv
rtl/glr_datapath.sv
rtl/glyph_line_rasterizer_top.sv
bench/glyph_line_rasterizer_top_test.sv
